[design/lkv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_pkg
// shared constants, types and controller/datapath interface for the lru cache
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int ENTRIES  = 16;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int RANK_W   = IDX_W;
  localparam int CAP_W    = 5;
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;

  localparam logic       CMD_GET   = 1'b0;
  localparam logic       CMD_SET   = 1'b1;
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;
  localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_UPDATE = 4'b0100,
    S_RESP   = 4'b1000
  } lkv_state_t;

  typedef struct packed {
    logic accept;    // latch the incoming word, restart the walk
    logic step;      // issue one entry read of the key walk
    logic update;    // apply the get/set outcome to the store
    logic load_out;  // move the result into the output register
  } lkv_cmd_t;

  typedef struct packed {
    logic issue_done;  // walk pointer has passed the last occupied entry
    logic out_free;    // output register can take a result this cycle
  } lkv_stat_t;

endpackage
`default_nettype wire

[design/lru_key_value_cache_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// a word is accepted, the key walk compares its key with each occupied entry, the store
//   is updated and the result moves to the output register; only then is a new word taken;
//   the key walk reads the key memory one entry per cycle over the occupied entries
// a finished result waits in the output register while the next word is taken
// reset (rst_n low, synchronous): store empty, capacity 16, channels idle;
//   entry memories are not cleared, the fill count bounds what is read
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// fully associative key/value store with least recently used replacement
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [63:0] in_tdata,   // [31:0] key, [63:32] value
  input  wire [0:0]  in_tuser,   // [0] command (0 get, 1 set)
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [31:0] out_tdata, // [31:0] read_value
  output logic [0:0] out_tuser,  // [0] hit
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [4:0]  cfg_data    // [4:0] cache_capacity
);
  import lkv_pkg::*;

  lkv_cmd_t  cmd;
  lkv_stat_t stat;
  logic      in_ready;

  assign in_tready = in_ready;
  assign cfg_ready = 1'b1;

  lkv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lkv_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_command (in_tuser[0]),
    .in_key     (in_tdata[31:0]),
    .in_value   (in_tdata[63:32]),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_cap    (cfg_data),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_hit    (out_tuser[0]),
    .out_value  (out_tdata)
  );

endmodule
`default_nettype wire

[design/lkv_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_ctrl
// sequencer: accept, walk the entries, update the store, hand off the result
// ----------------------------------------------------------------------------
module lkv_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  lkv_pkg::lkv_stat_t stat,
  output lkv_pkg::lkv_cmd_t  cmd
);
  import lkv_pkg::*;

  lkv_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_SEARCH;
        end
      end
      S_SEARCH: begin
        // last compare lands at the edge that leaves this state
        if (stat.issue_done) begin
          state_nxt = S_UPDATE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[design/lkv_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_dpath
// key/value memories, recency ranks, fill count, walk and output register
// ----------------------------------------------------------------------------
module lkv_dpath (
  input  wire                        clk,
  input  wire                        rst_n,
  input  lkv_pkg::lkv_cmd_t          cmd,
  output lkv_pkg::lkv_stat_t         stat,
  input  wire                        in_command,
  input  wire  [lkv_pkg::KEY_W-1:0]  in_key,
  input  wire  [lkv_pkg::VAL_W-1:0]  in_value,
  input  wire                        cfg_we,
  input  wire  [lkv_pkg::CAP_W-1:0]  cfg_cap,
  input  wire                        out_ready,
  output logic                       out_valid,
  output logic                       out_hit,
  output logic [lkv_pkg::VAL_W-1:0]  out_value
);
  import lkv_pkg::*;

  logic [KEY_W-1:0]  key_mem [ENTRIES];
  logic [VAL_W-1:0]  val_mem [ENTRIES];
  logic [RANK_W-1:0] rank_r  [ENTRIES];

  logic [CAP_W-1:0]  cap_r;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic              cmd_r;
  logic [KEY_W-1:0]  key_r;
  logic [VAL_W-1:0]  val_r;

  logic [CNT_W-1:0]  idx_r;
  logic              qv_r;
  logic [IDX_W-1:0]  qidx_r;
  logic [KEY_W-1:0]  key_q_r;
  logic              found_r;
  logic [IDX_W-1:0]  slot_r;
  logic [RANK_W-1:0] worst_r;
  logic [IDX_W-1:0]  lru_r;
  logic [VAL_W-1:0]  val_q_r;

  logic              out_valid_r, out_valid_nxt;
  logic              out_hit_r;
  logic [VAL_W-1:0]  out_value_r;

  logic [CNT_W-1:0]  eff_cap;
  logic              room;
  logic              all_inc;
  logic [RANK_W-1:0] ref_rank;
  logic [IDX_W-1:0]  tgt;
  logic              do_touch;
  logic              wr_key;
  logic              wr_val;

  assign stat.issue_done = (idx_r >= fill_r);
  assign stat.out_free   = !out_valid_r || out_ready;

  // capacity of zero acts as one, anything above the array size is clamped
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CNT_W'(1);
    end else if (32'(cap_r) > ENTRIES) begin
      eff_cap = CNT_W'(ENTRIES);
    end else begin
      eff_cap = CNT_W'(cap_r);
    end
  end

  always_comb begin
    room     = (fill_r < eff_cap);
    all_inc  = 1'b0;
    ref_rank = '0;
    tgt      = slot_r;
    if (found_r) begin
      ref_rank = rank_r[slot_r];
    end else if (room) begin
      all_inc = 1'b1;
      tgt     = fill_r[IDX_W-1:0];
    end else begin
      ref_rank = worst_r;
      tgt      = lru_r;
    end
    do_touch = cmd.update && (found_r || (cmd_r == CMD_SET));
    wr_val   = cmd.update && (cmd_r == CMD_SET);
    wr_key   = wr_val && !found_r;
  end

  always_comb begin
    fill_nxt = fill_r;
    if (wr_key && room) begin
      fill_nxt = fill_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAP_RESET;
      fill_r <= '0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_cap;
      end
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cmd_r <= in_command;
      key_r <= in_key;
      val_r <= in_value;
    end
  end

  // key memory: one read per walk step, written on a set that misses
  always_ff @(posedge clk) begin
    if (wr_key) begin
      key_mem[tgt] <= key_r;
    end
    if (cmd.step) begin
      key_q_r <= key_mem[idx_r[IDX_W-1:0]];
      qidx_r  <= idx_r[IDX_W-1:0];
    end
  end

  // value memory: read of the hit slot while the update is applied
  always_ff @(posedge clk) begin
    if (wr_val) begin
      val_mem[tgt] <= val_r;
    end
    if (cmd.update) begin
      val_q_r <= val_mem[slot_r];
    end
  end

  // walk: issue stage then compare stage, tracking first match and oldest entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      qv_r    <= 1'b0;
      found_r <= 1'b0;
    end else if (cmd.accept) begin
      idx_r   <= '0;
      qv_r    <= 1'b0;
      found_r <= 1'b0;
      worst_r <= '0;
      lru_r   <= '0;
    end else begin
      qv_r <= cmd.step && !stat.issue_done;
      if (cmd.step && !stat.issue_done) begin
        idx_r <= idx_r + CNT_W'(1);
      end
      if (qv_r) begin
        if (!found_r && (key_q_r == key_r)) begin
          found_r <= 1'b1;
          slot_r  <= qidx_r;
        end
        if (rank_r[qidx_r] >= worst_r) begin
          worst_r <= rank_r[qidx_r];
          lru_r   <= qidx_r;
        end
      end
    end
  end

  // recency: occupied entries newer than the touched one age by one
  always_ff @(posedge clk) begin
    if (do_touch) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if ((CNT_W'(i) < fill_r) && (all_inc || (rank_r[i] < ref_rank))) begin
          rank_r[i] <= rank_r[i] + RANK_W'(1);
        end
      end
      rank_r[tgt] <= '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_hit_r <= found_r;
      if (cmd_r == CMD_SET) begin
        out_value_r <= '0;
      end else if (found_r) begin
        out_value_r <= val_q_r;
      end else begin
        out_value_r <= MISS_VALUE;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;
  assign out_value = out_value_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= ENTRIES)
    else $error("fill count above array size");

  a_get_miss_keeps_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.update && !found_r && (cmd_r == CMD_GET)) |=> $stable(fill_r))
    else $error("get miss changed fill count");

  a_hit_slot_occupied: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.update && found_r) |-> (CNT_W'(slot_r) < fill_r))
    else $error("hit slot outside occupied range");

  a_lru_is_oldest: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.update && !found_r && !room) |-> (worst_r == RANK_W'(fill_r - CNT_W'(1))))
    else $error("eviction victim is not the oldest entry");

endmodule
`default_nettype wire
